/* rtl/greedy_change_maker_assert.svh */
// Assertion macros for the greedy change maker.
`ifndef GREEDY_CHANGE_MAKER_ASSERT_SVH
`define GREEDY_CHANGE_MAKER_ASSERT_SVH

`ifndef SYNTHESIS
`define GCM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("greedy_change_maker: assertion failed");
`define GCM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("greedy_change_maker: implication failed");
`else
`define GCM_ASSERT(name, prop)
`define GCM_ASSERT_IMP(name, ante, cons)
`endif

`endif

/* rtl/gcm_pkg.sv */
// Shared constants and types for the greedy change maker.
package gcm_pkg;

  localparam int unsigned AMOUNT_BITS = 16;
  localparam int unsigned COIN_BITS   = 16;
  localparam int unsigned NUM_SLOTS   = 8;
  localparam int unsigned SLOT_BITS   = $clog2(NUM_SLOTS);
  localparam int unsigned ADDR_BITS   = SLOT_BITS + 2;
  localparam int unsigned DATA_BITS   = 32;

  typedef logic [COIN_BITS-1:0]   coin_t;
  typedef logic [AMOUNT_BITS-1:0] amount_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;

  localparam slot_t SLOT_FIRST = slot_t'(0);
  localparam slot_t SLOT_LAST  = slot_t'(NUM_SLOTS - 1);

  localparam coin_t COIN_RESET [NUM_SLOTS] = '{
    coin_t'(200), coin_t'(100), coin_t'(50), coin_t'(20),
    coin_t'(10),  coin_t'(5),   coin_t'(2),  coin_t'(1)
  };

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/gcm_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`include "greedy_change_maker_assert.svh"

module gcm_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gcm_pkg::AMOUNT_BITS-1:0] dividend_i,
  input  logic [gcm_pkg::COIN_BITS-1:0]   divisor_i,
  output gcm_pkg::div_stat_t            stat_o,
  output logic [gcm_pkg::AMOUNT_BITS-1:0] quotient_o,
  output logic [gcm_pkg::AMOUNT_BITS-1:0] remainder_o
);
  import gcm_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(AMOUNT_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(AMOUNT_BITS - 1);

  amount_t             rem_q;
  amount_t             quo_q;
  coin_t               divisor_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [AMOUNT_BITS:0]   shifted;
  logic [AMOUNT_BITS+1:0] diff;
  logic                   fits;

  // Bring down the next dividend bit and try the divisor.
  assign shifted = {rem_q, quo_q[AMOUNT_BITS-1]};
  assign diff    = {1'b0, shifted} - (AMOUNT_BITS+2)'(divisor_q);
  assign fits    = ~diff[AMOUNT_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[AMOUNT_BITS-1:0] : shifted[AMOUNT_BITS-1:0];
      quo_q <= {quo_q[AMOUNT_BITS-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  `GCM_ASSERT_IMP(a_rem_below_divisor, stat_o.done && divisor_q != '0, rem_q < divisor_q)
  `GCM_ASSERT(a_done_after_run, done_q |-> $past(busy_q))

endmodule

/* rtl/greedy_change_maker.sv */
// Greedy coin change: top level with register file and slot sequencer.
//
// A request is taken when start_i is high and busy_o is low. The amount is
// split over the eight coin registers in index order, and one result per
// coin is shown for a single cycle with result_valid_o; the receiver cannot
// stall, so it must take every strobe. For each coin the sequencer passes
// through a launch state, the bit-serial divider produces one quotient bit
// per cycle, and the result is then registered. busy_o falls with the
// eighth result. Coin registers sit at byte addresses 0, 4, ... 28 on the
// APB port and may be written only while idle.
`include "greedy_change_maker_assert.svh"

module greedy_change_maker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gcm_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [gcm_pkg::DATA_BITS-1:0]     pwdata,
  output logic [gcm_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [gcm_pkg::AMOUNT_BITS-1:0]   amount_i,
  output logic                              result_valid_o,
  output logic [gcm_pkg::SLOT_BITS-1:0]     coin_slot_o,
  output logic [gcm_pkg::AMOUNT_BITS-1:0]   coin_count_o,
  output logic [gcm_pkg::AMOUNT_BITS-1:0]   leftover_o,
  output logic                              last_slot_o
);
  import gcm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT
  } state_e;

  state_e    state_q;
  coin_t     coin_q     [NUM_SLOTS];
  coin_t     coin_sh_q  [NUM_SLOTS];
  amount_t   rest_q;
  slot_t     slot_q;
  logic      valid_q;
  slot_t     out_slot_q;
  amount_t   out_count_q;
  amount_t   out_left_q;
  logic      out_last_q;

  slot_t     reg_idx;
  logic      cfg_wr;
  logic      div_start;
  div_stat_t div_stat;
  amount_t   div_quo;
  amount_t   div_rem;
  logic      coin_zero;
  amount_t   slot_count;
  amount_t   slot_left;

  // Configuration registers.
  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = DATA_BITS'(coin_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        coin_q[k] <= COIN_RESET[k];
      end
    end else if (cfg_wr) begin
      coin_q[reg_idx] <= pwdata[COIN_BITS-1:0];
    end
  end

  assign div_start = (state_q == ST_LAUNCH);

  gcm_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (rest_q),
    .divisor_i   (coin_sh_q[0]),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // A zero coin takes nothing and passes the amount through.
  assign coin_zero  = (coin_sh_q[0] == '0);
  assign slot_count = coin_zero ? '0 : div_quo;
  assign slot_left  = coin_zero ? rest_q : div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= SLOT_FIRST;
      valid_q     <= 1'b0;
      out_last_q  <= 1'b0;
      out_slot_q  <= SLOT_FIRST;
      out_count_q <= '0;
      out_left_q  <= '0;
      rest_q      <= '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        coin_sh_q[k] <= '0;
      end
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            rest_q    <= amount_i[AMOUNT_BITS-1:0];
            coin_sh_q <= coin_q;
            slot_q    <= SLOT_FIRST;
            state_q   <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            valid_q     <= 1'b1;
            out_slot_q  <= slot_q;
            out_count_q <= slot_count;
            out_left_q  <= slot_left;
            out_last_q  <= (slot_q == SLOT_LAST);
            rest_q      <= slot_left;
            // advance to the next coin
            for (int k = 0; k < NUM_SLOTS - 1; k++) begin
              coin_sh_q[k] <= coin_sh_q[k+1];
            end
            coin_sh_q[NUM_SLOTS-1] <= '0;
            slot_q  <= SLOT_BITS'(slot_q + 1'b1);
            state_q <= (slot_q == SLOT_LAST) ? ST_IDLE : ST_LAUNCH;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign coin_slot_o    = out_slot_q;
  assign coin_count_o   = out_count_q;
  assign leftover_o     = out_left_q;
  assign last_slot_o    = out_last_q & valid_q;

  `GCM_ASSERT_IMP(a_launch_when_free, div_start, !div_stat.busy)
  `GCM_ASSERT(a_accept_fresh, (start_i && !busy_o) |=> (state_q == ST_LAUNCH && slot_q == SLOT_FIRST))
  `GCM_ASSERT_IMP(a_last_frees, result_valid_o && last_slot_o, !busy_o && coin_slot_o == SLOT_LAST)

endmodule
